// ----- rtl/sro_pkg.sv -----
`timescale 1ns / 1ps

package sro_pkg;

   // default sizing
   localparam int HOLD_CAPACITY_DEF = 15;
   localparam int TAG_WIDTH_DEF     = 16;

   // fixed field widths
   localparam int SEQ_WIDTH  = 32;
   localparam int KIND_WIDTH = 2;

   // result kinds
   localparam logic [KIND_WIDTH-1:0] KIND_PASS     = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_IN_ORDER = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_FLUSHED  = 2'd2;

   // command broadcast to every cell of the chain
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_SHIFT  = 2'd2
   } cell_op_type;

   // what the chain reports back to the controller
   typedef struct packed {
      logic                 head_valid;
      logic [SEQ_WIDTH-1:0] head_seq;
      logic                 next_valid;
      logic [SEQ_WIDTH-1:0] next_seq;
      logic                 dup;
      logic                 near_full;
      logic                 full;
   } chain_status_type;

endpackage

// ----- rtl/sro_cell.sv -----
`timescale 1ns / 1ps

module sro_cell #(
   parameter int TAG_WIDTH = sro_pkg::TAG_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sro_pkg::cell_op_type          op,
   input  logic                          dup,
   input  logic [sro_pkg::SEQ_WIDTH-1:0] key,
   input  logic [TAG_WIDTH-1:0]          new_tag,
   input  logic                          left_valid,
   input  logic [sro_pkg::SEQ_WIDTH-1:0] left_seq,
   input  logic [TAG_WIDTH-1:0]          left_tag,
   input  logic                          left_lt,
   input  logic                          right_valid,
   input  logic [sro_pkg::SEQ_WIDTH-1:0] right_seq,
   input  logic [TAG_WIDTH-1:0]          right_tag,
   output logic                          valid,
   output logic [sro_pkg::SEQ_WIDTH-1:0] seq,
   output logic [TAG_WIDTH-1:0]          tag,
   output logic                          lt,
   output logic                          eq
);
   import sro_pkg::*;

   logic                 valid_ff, valid_in;
   logic [SEQ_WIDTH-1:0] seq_ff, seq_in;
   logic [TAG_WIDTH-1:0] tag_ff, tag_in;

   // local compares against the broadcast key
   assign lt = valid_ff && (seq_ff < key);
   assign eq = valid_ff && (seq_ff == key);

   // next entry: keep, take the new item, take from left or from right
   always_comb begin
      valid_in = valid_ff;
      seq_in   = seq_ff;
      tag_in   = tag_ff;
      case (op)
         CELL_INSERT: begin
            if (dup) begin
               if (eq) begin
                  tag_in = new_tag;
               end
            end else if (!lt) begin
               if (left_lt) begin
                  valid_in = 1'b1;
                  seq_in   = key;
                  tag_in   = new_tag;
               end else begin
                  valid_in = left_valid;
                  seq_in   = left_seq;
                  tag_in   = left_tag;
               end
            end
         end
         CELL_SHIFT: begin
            valid_in = right_valid;
            seq_in   = right_seq;
            tag_in   = right_tag;
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   // valid bit clears on reset, payload does not
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      seq_ff <= seq_in;
      tag_ff <= tag_in;
   end

   assign valid = valid_ff;
   assign seq   = seq_ff;
   assign tag   = tag_ff;

endmodule

// ----- rtl/sro_chain.sv -----
`timescale 1ns / 1ps

module sro_chain #(
   parameter int HOLD_CAPACITY = sro_pkg::HOLD_CAPACITY_DEF,
   parameter int TAG_WIDTH     = sro_pkg::TAG_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sro_pkg::cell_op_type          op,
   input  logic [sro_pkg::SEQ_WIDTH-1:0] key,
   input  logic [TAG_WIDTH-1:0]          new_tag,
   output sro_pkg::chain_status_type     status,
   output logic [TAG_WIDTH-1:0]          head_tag
);
   import sro_pkg::*;

   localparam int SLOTS = HOLD_CAPACITY + 1;

   logic [SLOTS-1:0]                valid_w, lt_w, eq_w;
   logic [SLOTS-1:0][SEQ_WIDTH-1:0] seq_w;
   logic [SLOTS-1:0][TAG_WIDTH-1:0] tag_w;
   logic                            dup;

   // a held copy of the key turns an insert into a tag overwrite
   assign dup = |eq_w;

   // cells kept packed at the low end, sorted by ascending number
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic                 l_valid, l_lt, r_valid;
      logic [SEQ_WIDTH-1:0] l_seq, r_seq;
      logic [TAG_WIDTH-1:0] l_tag, r_tag;

      if (i == 0) begin : g_first
         assign l_valid = 1'b0;
         assign l_lt    = 1'b1;
         assign l_seq   = '0;
         assign l_tag   = '0;
      end else begin : g_inner_l
         assign l_valid = valid_w[i-1];
         assign l_lt    = lt_w[i-1];
         assign l_seq   = seq_w[i-1];
         assign l_tag   = tag_w[i-1];
      end

      if (i == SLOTS - 1) begin : g_last
         assign r_valid = 1'b0;
         assign r_seq   = '0;
         assign r_tag   = '0;
      end else begin : g_inner_r
         assign r_valid = valid_w[i+1];
         assign r_seq   = seq_w[i+1];
         assign r_tag   = tag_w[i+1];
      end

      sro_cell #(
         .TAG_WIDTH(TAG_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .dup        (dup),
         .key        (key),
         .new_tag    (new_tag),
         .left_valid (l_valid),
         .left_seq   (l_seq),
         .left_tag   (l_tag),
         .left_lt    (l_lt),
         .right_valid(r_valid),
         .right_seq  (r_seq),
         .right_tag  (r_tag),
         .valid      (valid_w[i]),
         .seq        (seq_w[i]),
         .tag        (tag_w[i]),
         .lt         (lt_w[i]),
         .eq         (eq_w[i])
      );
   end

   // status toward the controller
   assign status.head_valid = valid_w[0];
   assign status.head_seq   = seq_w[0];
   assign status.next_valid = valid_w[1];
   assign status.next_seq   = seq_w[1];
   assign status.dup        = dup;
   assign status.near_full  = valid_w[SLOTS-2];
   assign status.full       = valid_w[SLOTS-1];
   assign head_tag          = tag_w[0];

endmodule

// ----- rtl/sequence_reorder_buffer.sv -----
`timescale 1ns / 1ps

// Reorders TCP packet descriptors by sequence number. Non-TCP descriptors, stale ones
// (number below the expected one) and out-of-order ones that only go into the hold table
// leave the sequencer idle. An in-order descriptor is released at once, followed by every
// held packet that continues the sequence, one result per cycle while rsp_stall is low;
// when an insert fills the table past HOLD_CAPACITY the expected number jumps to the
// smallest held one and that run is flushed the same way. The held packets live in a
// sorted chain of HOLD_CAPACITY + 1 cells, so the smallest held number is always at the
// head and each release is a shift of the chain; req_stall stays high while a run is
// being released.
module sequence_reorder_buffer #(
   parameter int HOLD_CAPACITY = sro_pkg::HOLD_CAPACITY_DEF,
   parameter int TAG_WIDTH     = sro_pkg::TAG_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_is_tcp,
   input  logic [sro_pkg::SEQ_WIDTH-1:0]  req_seq_num,
   input  logic [TAG_WIDTH-1:0]           req_packet_tag,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [TAG_WIDTH-1:0]           rsp_out_tag,
   output logic [sro_pkg::KIND_WIDTH-1:0] rsp_out_kind,
   output logic                           rsp_last_of_run
);
   import sro_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [SEQ_WIDTH-1:0] expected_ff, expected_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TAG_WIDTH-1:0]  rsp_tag_ff, rsp_tag_in;
   logic [KIND_WIDTH-1:0] rsp_kind_ff, rsp_kind_in;
   logic                  rsp_last_ff, rsp_last_in;

   chain_status_type     status;
   logic [TAG_WIDTH-1:0] head_tag;
   cell_op_type          chain_op;

   logic                 out_free, accept, in_order, stale;
   logic [SEQ_WIDTH-1:0] seq_plus, head_plus;
   logic                 in_order_last, run_last, run_step;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign run_step  = (state_ff == ST_RUN) && out_free;

   // classification of the incoming descriptor
   assign in_order  = req_is_tcp && (req_seq_num == expected_ff);
   assign stale     = req_is_tcp && (req_seq_num < expected_ff);
   assign seq_plus  = req_seq_num + 1'b1;
   assign head_plus = status.head_seq + 1'b1;

   // lookahead: does the head continue the run after this result
   assign in_order_last = !(status.head_valid && (status.head_seq == seq_plus));
   assign run_last      = !(status.next_valid && (status.next_seq == head_plus));

   // chain command
   always_comb begin
      chain_op = CELL_HOLD;
      if (accept && req_is_tcp && !in_order && !stale) begin
         chain_op = CELL_INSERT;
      end else if (run_step) begin
         chain_op = CELL_SHIFT;
      end
   end

   sro_chain #(
      .HOLD_CAPACITY(HOLD_CAPACITY),
      .TAG_WIDTH    (TAG_WIDTH)
   ) u_chain (
      .clock   (clock),
      .reset   (reset),
      .op      (chain_op),
      .key     (req_seq_num),
      .new_tag (req_packet_tag),
      .status  (status),
      .head_tag(head_tag)
   );

   // sequencer, expected number and output register
   always_comb begin
      state_in     = state_ff;
      expected_in  = expected_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_tag_in   = rsp_tag_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_is_tcp) begin
                  rsp_valid_in = 1'b1;
                  rsp_tag_in   = req_packet_tag;
                  rsp_kind_in  = KIND_PASS;
                  rsp_last_in  = 1'b1;
               end else if (in_order) begin
                  rsp_valid_in = 1'b1;
                  rsp_tag_in   = req_packet_tag;
                  rsp_kind_in  = KIND_IN_ORDER;
                  rsp_last_in  = in_order_last;
                  expected_in  = seq_plus;
                  if (!in_order_last) begin
                     state_in = ST_RUN;
                  end
               end else if (!stale && !status.dup && status.near_full) begin
                  // insert overflows the table: flush from the smallest held number
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (run_step) begin
               rsp_valid_in = 1'b1;
               rsp_tag_in   = head_tag;
               rsp_kind_in  = KIND_FLUSHED;
               rsp_last_in  = run_last;
               expected_in  = head_plus;
               if (run_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         expected_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         expected_ff  <= expected_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_tag_ff  <= rsp_tag_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_tag     = rsp_tag_ff;
   assign rsp_out_kind    = rsp_kind_ff;
   assign rsp_last_of_run = rsp_last_ff;

`ifndef ASSERT_OFF
   // a run always has a held packet at the head of the chain
   a_run_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> status.head_valid)
      else $error("run active with empty chain head");

   // a transfer that is not last leaves more of the run to come
   a_not_last_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_of_run) |-> (state_ff == ST_RUN))
      else $error("non-last result without a run in progress");

   // a full chain is only ever seen while it is being flushed
   a_full_flush: assert property (@(posedge clock) disable iff (reset)
      status.full |-> (state_ff == ST_RUN))
      else $error("hold table full outside a flush");

   // the result kind never takes the unused code
   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_kind == KIND_PASS || rsp_out_kind == KIND_IN_ORDER ||
                     rsp_out_kind == KIND_FLUSHED))
      else $error("illegal result kind");
`endif

endmodule
